FILE: rtl/jlvp_pkg.sv
// shared types, constants and helpers for the jerk-limited velocity profiler
package jlvp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DT_BITS   = 16;
    localparam int WORD_BITS = 32;
    localparam int REG_BITS  = 31;
    localparam int MUL_BITS  = 33;
    localparam int PROD_BITS = 2 * MUL_BITS;
    localparam int WIDE_BITS = 52;
    localparam int GUARD_LSB = ((1 << FRAC_BITS) + 500) / 1000;
    localparam int DIV_STEPS = 31;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [REG_BITS-1:0]         reg_t;
    typedef logic signed [MUL_BITS-1:0]  mul_op_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [WIDE_BITS-1:0] wide_t;

    typedef logic [1:0] phase_t;
    localparam phase_t PH_IDLE   = 2'd0;
    localparam phase_t PH_CRUISE = 2'd1;
    localparam phase_t PH_SCURVE = 2'd2;
    localparam phase_t PH_RAMP   = 2'd3;

    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t REG_JERK  = 3'd0;
    localparam cfg_index_t REG_ACCEL = 3'd1;
    localparam cfg_index_t REG_DECEL = 3'd2;
    localparam cfg_index_t REG_TAPER = 3'd3;
    localparam cfg_index_t REG_MID   = 3'd4;
    localparam cfg_index_t REG_CAP   = 3'd5;
    localparam cfg_index_t REG_BRAKE = 3'd6;
    localparam cfg_index_t REG_END   = 3'd7;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // saturate a wide signed value to the signed word range
    function automatic word_t sat_word(input wide_t x);
        word_t res;
        if (x > wide_t'(WORD_MAX))
            res = WORD_MAX;
        else if (x < wide_t'(WORD_MIN))
            res = WORD_MIN;
        else
            res = x[WORD_BITS-1:0];
        return res;
    endfunction

endpackage

FILE: rtl/jlvp_ifs.sv
// valid/ready channels carrying the profiler's input and result beats
interface jlvp_in_if;
    logic                valid;
    logic                ready;
    logic                op;
    logic signed [31:0]  distance_left;
    logic [15:0]         tick_period;
    logic signed [31:0]  start_velocity;

    modport source (output valid, op, distance_left, tick_period, start_velocity,
                    input ready);
    modport sink   (input valid, op, distance_left, tick_period, start_velocity,
                    output ready);
endinterface

interface jlvp_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] velocity_out;
    logic [1:0]  phase;

    modport source (output valid, velocity_out, phase, input ready);
    modport sink   (input valid, velocity_out, phase, output ready);
endinterface

FILE: rtl/jerk_limited_velocity_profiler.sv
// top level of the jerk-limited velocity profiler
// One beat at a time. A start beat, or a tick before any start, goes straight to DONE and on
// to the result register. A cruise tick runs JD, BRANCH, VEL_MUL and VEL_ADD; an s-curve tick
// runs ACC_DEC before VEL_MUL, with the stopping test STOP_A to STOP_C ahead of it when it runs
// it. A final ramp tick, once the slope is latched or when the distance is zero, runs JD,
// BRANCH, LATCH, RAMP_MUL and RAMP_ADD; the first ramp tick reached through the stopping test
// runs LATCH after STOP_C, and DIV after LATCH when the slope is divided out. The single shared
// 33x33 multiplier gives one registered product per cycle, and the restoring divider yields
// one slope bit per cycle. DONE waits while the previous result is still held in the output
// register. The input is not ready while a beat is being worked and is ready again in the cycle
// the result register is loaded, so a new beat is taken while the previous result waits.
module jerk_limited_velocity_profiler (
    input  logic                 clk,
    input  logic                 rst_n,
    jlvp_in_if.sink              in_ch,
    jlvp_out_if.source           out_ch,
    input  logic                 cfg_we,
    input  jlvp_pkg::cfg_index_t cfg_index,
    input  jlvp_pkg::reg_t       cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_JD, ST_BRANCH, ST_STOP_A, ST_STOP_B, ST_STOP_C, ST_ACC_DEC,
        ST_VEL_MUL, ST_VEL_ADD, ST_LATCH, ST_DIV, ST_RAMP_MUL, ST_RAMP_ADD, ST_DONE
    } state_t;

    // configuration registers
    jlvp_pkg::reg_t jerk_reg, accel_reg, decel_reg, taper_reg, cap_reg;
    jlvp_pkg::reg_t brake_reg, end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jerk_reg  <= '0;
            accel_reg <= '0;
            decel_reg <= '0;
            taper_reg <= '0;
            cap_reg   <= '0;
            brake_reg <= '0;
            end_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                jlvp_pkg::REG_JERK:  jerk_reg  <= cfg_data;
                jlvp_pkg::REG_ACCEL: accel_reg <= cfg_data;
                jlvp_pkg::REG_DECEL: decel_reg <= cfg_data;
                jlvp_pkg::REG_TAPER: taper_reg <= cfg_data;
                // decel_mid_velocity splits two identical branches, so it needs no storage
                jlvp_pkg::REG_MID:   ;
                jlvp_pkg::REG_CAP:   cap_reg   <= cfg_data;
                jlvp_pkg::REG_BRAKE: brake_reg <= cfg_data;
                jlvp_pkg::REG_END:   end_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // profile state and working registers
    state_t          state_reg, state_next;
    jlvp_pkg::word_t vel_reg, vel_next;
    jlvp_pkg::word_t acc_reg, acc_next;
    jlvp_pkg::word_t slope_reg, slope_next;
    logic            final_reg, final_next;
    logic            started_reg, started_next;
    logic            accel_mode_reg, accel_mode_next;
    logic [31:0]     r_reg, r_next;
    logic [15:0]     dt_reg, dt_next;
    logic [30:0]     jd_reg, jd_next;
    logic [63:0]     hold_reg, hold_next;
    logic [31:0]     rem_reg, rem_next;
    logic [30:0]     num_reg, num_next;
    logic [4:0]      cnt_reg, cnt_next;
    jlvp_pkg::word_t res_reg, res_next;
    jlvp_pkg::phase_t ph_reg, ph_next;
    logic            out_valid_reg, out_valid_next;
    logic [30:0]     out_vel_reg, out_vel_next;
    jlvp_pkg::phase_t out_ph_reg, out_ph_next;

    // shared multiplier
    jlvp_pkg::mul_op_t mul_a, mul_b;
    jlvp_pkg::prod_t   prod;

    jlvp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // common terms
    logic signed [32:0] v_ext, t_ext, vmt, vpt, cap_ext, taper_ext;
    logic               v_gt_t;
    logic [30:0]        jd_now;
    logic signed [33:0] acc34, dif_now, sum_now, dif_dec, neg_decel;
    logic signed [32:0] sv_abs, rd_abs;
    logic [32:0]        cand;
    logic               cand_ge;
    logic [32:0]        cand_sub;
    jlvp_pkg::word_t    vnew;
    logic [30:0]        ramp_add;
    logic [32:0]        ramp_sum;

    assign v_ext     = {vel_reg[31], vel_reg};
    assign t_ext     = {2'b00, end_reg};
    assign cap_ext   = {2'b00, cap_reg};
    assign taper_ext = {2'b00, taper_reg};
    assign vmt       = v_ext - t_ext;
    assign vpt       = v_ext + t_ext;
    assign v_gt_t    = v_ext > t_ext;
    assign jd_now    = prod[46:16];
    assign acc34     = {{2{acc_reg[31]}}, acc_reg};
    assign dif_now   = acc34 - $signed({3'b000, jd_now});
    assign sum_now   = acc34 + $signed({3'b000, jd_now});
    assign dif_dec   = acc34 - $signed({3'b000, jd_reg});
    assign neg_decel = -$signed({3'b000, decel_reg});
    assign sv_abs    = in_ch.start_velocity[31] ?
                       -{in_ch.start_velocity[31], in_ch.start_velocity} :
                       {1'b0, in_ch.start_velocity};
    assign rd_abs    = in_ch.distance_left[31] ?
                       -{in_ch.distance_left[31], in_ch.distance_left} :
                       {1'b0, in_ch.distance_left};
    // one restoring division step
    assign cand      = {rem_reg, num_reg[30]};
    assign cand_ge   = cand >= {1'b0, r_reg};
    assign cand_sub  = cand - {1'b0, r_reg};
    // velocity plus floored acc*dt
    assign vnew      = jlvp_pkg::sat_word({{20{vel_reg[31]}}, vel_reg}
                                          + {{2{prod[65]}}, prod[65:16]});
    // slope*r scaled, saturated to the word
    assign ramp_add  = (prod[65:47] != '0) ? 31'h7FFF_FFFF : prod[46:16];
    assign ramp_sum  = {2'b00, end_reg}
                       + ((slope_reg > 0) ? {2'b00, ramp_add} : 33'd0);

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_JD:
            begin
                mul_a = {2'b00, jerk_reg};
                mul_b = {17'd0, dt_reg};
            end
            ST_STOP_A:
            begin
                mul_a = vmt;
                mul_b = vpt;
            end
            ST_STOP_B:
            begin
                mul_a = {1'b0, r_reg};
                mul_b = {1'b0, decel_reg, 1'b0};
            end
            ST_VEL_MUL:
            begin
                mul_a = {acc_reg[31], acc_reg};
                mul_b = {17'd0, dt_reg};
            end
            ST_RAMP_MUL:
            begin
                mul_a = {slope_reg[31], slope_reg};
                mul_b = {1'b0, r_reg};
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        vel_next        = vel_reg;
        acc_next        = acc_reg;
        slope_next      = slope_reg;
        final_next      = final_reg;
        started_next    = started_reg;
        accel_mode_next = accel_mode_reg;
        r_next          = r_reg;
        dt_next         = dt_reg;
        jd_next         = jd_reg;
        hold_next       = hold_reg;
        rem_next        = rem_reg;
        num_next        = num_reg;
        cnt_next        = cnt_reg;
        res_next        = res_reg;
        ph_next         = ph_reg;
        out_vel_next    = out_vel_reg;
        out_ph_next     = out_ph_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.op)
                    begin
                        vel_next     = sv_abs[31] ? jlvp_pkg::WORD_MAX : sv_abs[31:0];
                        acc_next     = '0;
                        final_next   = 1'b0;
                        started_next = 1'b1;
                        res_next     = sv_abs[31] ? jlvp_pkg::WORD_MAX : sv_abs[31:0];
                        ph_next      = jlvp_pkg::PH_CRUISE;
                        state_next   = ST_DONE;
                    end
                    else if (!started_reg)
                    begin
                        res_next   = '0;
                        ph_next    = jlvp_pkg::PH_IDLE;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        r_next     = rd_abs[31:0];
                        dt_next    = in_ch.tick_period;
                        state_next = ST_JD;
                    end
                end
            end
            ST_JD:
                state_next = ST_BRANCH;
            ST_BRANCH:
            begin
                jd_next = jd_now;
                if (r_reg > {1'b0, brake_reg})
                begin
                    // accelerate or cruise
                    accel_mode_next = 1'b1;
                    if (v_ext >= taper_ext)
                        acc_next = dif_now[33] ? '0 : dif_now[31:0];
                    else if (sum_now > $signed({3'b000, accel_reg}))
                        acc_next = {1'b0, accel_reg};
                    else
                        acc_next = sum_now[31:0];
                    state_next = ST_VEL_MUL;
                end
                else
                begin
                    accel_mode_next = 1'b0;
                    if (final_reg || r_reg == '0)
                        state_next = ST_LATCH;
                    else if (v_gt_t && decel_reg > 31'(jlvp_pkg::GUARD_LSB))
                        state_next = ST_STOP_A;
                    else
                        state_next = ST_ACC_DEC;
                end
            end
            ST_STOP_A:
                state_next = ST_STOP_B;
            ST_STOP_B:
            begin
                hold_next  = prod[63:0];
                state_next = ST_STOP_C;
            end
            ST_STOP_C:
            begin
                // stopping distance reached when (v-t)(v+t) >= 2*d*r
                if (hold_reg >= prod[63:0])
                    state_next = ST_LATCH;
                else
                    state_next = ST_ACC_DEC;
            end
            ST_ACC_DEC:
            begin
                if (dif_dec <= neg_decel)
                    acc_next = neg_decel[31:0];
                else
                    acc_next = dif_dec[31:0];
                state_next = ST_VEL_MUL;
            end
            ST_VEL_MUL:
                state_next = ST_VEL_ADD;
            ST_VEL_ADD:
            begin
                if (accel_mode_reg)
                begin
                    if ($signed({vnew[31], vnew}) >= cap_ext)
                    begin
                        acc_next = '0;
                        vel_next = {1'b0, cap_reg};
                        res_next = {1'b0, cap_reg};
                    end
                    else
                    begin
                        vel_next = vnew;
                        res_next = vnew;
                    end
                    ph_next = jlvp_pkg::PH_CRUISE;
                end
                else
                begin
                    vel_next = vnew;
                    res_next = ($signed({vnew[31], vnew}) > t_ext) ? vnew : {1'b0, end_reg};
                    ph_next  = jlvp_pkg::PH_SCURVE;
                end
                state_next = ST_DONE;
            end
            ST_LATCH:
            begin
                if (final_reg)
                    state_next = ST_RAMP_MUL;
                else
                begin
                    final_next = 1'b1;
                    if (r_reg > 32'(jlvp_pkg::GUARD_LSB) && v_gt_t)
                    begin
                        // quotient of 2^31 or more saturates
                        if ({16'd0, vmt[30:0]} >= {r_reg, 15'd0})
                        begin
                            slope_next = jlvp_pkg::WORD_MAX;
                            state_next = ST_RAMP_MUL;
                        end
                        else
                        begin
                            slope_next = '0;
                            rem_next   = {16'd0, vmt[30:15]};
                            num_next   = {vmt[14:0], 16'd0};
                            cnt_next   = '0;
                            state_next = ST_DIV;
                        end
                    end
                    else
                    begin
                        slope_next = '0;
                        state_next = ST_RAMP_MUL;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next   = cand_ge ? cand_sub[31:0] : cand[31:0];
                num_next   = {num_reg[29:0], 1'b0};
                slope_next = {slope_reg[30:0], cand_ge};
                cnt_next   = cnt_reg + 5'd1;
                if (cnt_reg == 5'(jlvp_pkg::DIV_STEPS - 1))
                    state_next = ST_RAMP_MUL;
            end
            ST_RAMP_MUL:
                state_next = ST_RAMP_ADD;
            ST_RAMP_ADD:
            begin
                vel_next   = ramp_sum[32:31] != 2'b00 ? jlvp_pkg::WORD_MAX : ramp_sum[31:0];
                res_next   = ramp_sum[32:31] != 2'b00 ? jlvp_pkg::WORD_MAX : ramp_sum[31:0];
                acc_next   = '0;
                ph_next    = jlvp_pkg::PH_RAMP;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_vel_next   = res_reg[31] ? '0 : res_reg[30:0];
                    out_ph_next    = ph_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vel_reg       <= '0;
            acc_reg       <= '0;
            slope_reg     <= '0;
            final_reg     <= 1'b0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vel_reg       <= vel_next;
            acc_reg       <= acc_next;
            slope_reg     <= slope_next;
            final_reg     <= final_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working payload, no reset needed
    always_ff @(posedge clk)
    begin
        accel_mode_reg <= accel_mode_next;
        r_reg          <= r_next;
        dt_reg         <= dt_next;
        jd_reg         <= jd_next;
        hold_reg       <= hold_next;
        rem_reg        <= rem_next;
        num_reg        <= num_next;
        cnt_reg        <= cnt_next;
        res_reg        <= res_next;
        ph_reg         <= ph_next;
        out_vel_reg    <= out_vel_next;
        out_ph_reg     <= out_ph_next;
    end

    assign in_ch.ready         = (state_reg == ST_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.velocity_out = out_vel_reg;
    assign out_ch.phase        = out_ph_reg;

    // the final ramp is only reachable after a start
    assert property (@(posedge clk) disable iff (!rst_n) final_reg |-> started_reg)
        else $error("final ramp active without a start");

    // the latched slope never goes negative
    assert property (@(posedge clk) disable iff (!rst_n) !slope_reg[31])
        else $error("ramp slope negative");

    // an accepted start beat leaves the block started
    assert property (@(posedge clk) disable iff (!rst_n)
                     in_ch.valid && in_ch.ready && in_ch.op |=> started_reg)
        else $error("start beat did not mark the block started");

    // an idle-phase result always carries zero velocity
    assert property (@(posedge clk) disable iff (!rst_n)
                     out_ch.valid && out_ch.phase == jlvp_pkg::PH_IDLE
                     |-> out_ch.velocity_out == '0)
        else $error("idle result with non-zero velocity");

endmodule

FILE: rtl/jlvp_mul.sv
// shared signed multiplier with registered product
module jlvp_mul (
    input  logic             clk,
    input  jlvp_pkg::mul_op_t a,
    input  jlvp_pkg::mul_op_t b,
    output jlvp_pkg::prod_t   p
);

    jlvp_pkg::prod_t p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule
